@@ src/v210_pkg.sv @@
// Shared types, constants and helpers for the v210 4:2:2 packer.
package v210_pkg;

	localparam int SAMPLE_W  = 10;
	localparam int WORD_W    = 32;
	localparam int STRIDE_W  = 16;
	localparam int PARTIAL_W = 20;
	localparam int MAX_PAD   = 32;
	localparam int PAD_W     = $clog2(MAX_PAD + 1);
	localparam int NDATA     = 3;
	localparam int NDATA_W   = $clog2(NDATA + 1);

	localparam logic [SAMPLE_W-1:0] SAMPLE_LO = SAMPLE_W'(4);
	localparam logic [SAMPLE_W-1:0] SAMPLE_HI = SAMPLE_W'(1019);

	localparam logic [STRIDE_W-1:0] WIL_MAX = {STRIDE_W{1'b1}};

	typedef logic [SAMPLE_W-1:0]  sample_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [PARTIAL_W-1:0] partial_t;
	typedef logic [STRIDE_W-1:0]  stride_t;
	typedef logic [PAD_W-1:0]     pad_t;
	typedef logic [NDATA_W-1:0]   ndata_t;

	// position of the next pair inside the three-pair group
	typedef enum logic [1:0] {
		PH_START  = 2'd0,
		PH_ONE    = 2'd1,
		PH_TWO    = 2'd2,
		PH_UNUSED = 2'd3
	} phase_t;

	function automatic sample_t clip_sample(input sample_t s);
		sample_t r;
		if (s < SAMPLE_LO) begin
			r = SAMPLE_LO;
		end else if (s > SAMPLE_HI) begin
			r = SAMPLE_HI;
		end else begin
			r = s;
		end
		return r;
	endfunction

	function automatic word_t pack3(input sample_t a, input sample_t b, input sample_t c);
		return {2'b00, c, b, a};
	endfunction

endpackage

@@ src/v210_pair_if.sv @@
// Stream interfaces: pixel pairs in, packed words out.
interface v210_pair_if;
	import v210_pkg::*;

	logic    valid;
	logic    ready;
	sample_t cb;
	sample_t y_first;
	sample_t cr;
	sample_t y_second;
	logic    end_of_line;

	modport source (output valid, cb, y_first, cr, y_second, end_of_line, input ready);
	modport sink   (input valid, cb, y_first, cr, y_second, end_of_line, output ready);
endinterface

interface v210_word_if;
	import v210_pkg::*;

	logic  valid;
	logic  ready;
	word_t word;
	logic  line_end;
	logic  last_of_run;

	modport source (output valid, word, line_end, last_of_run, input ready);
	modport sink   (input valid, word, line_end, last_of_run, output ready);
endinterface

@@ src/v210_ycbcr422_packer.sv @@
// v210 packer: one 4:2:2 pair per request in, one 32-bit word per cycle out unless stalled.
// The first word of a request is registered in the item stage, then in the output stage.
// Throughput: one word per cycle unless stalled; a pair holds the item stage
// for 1 or 2 data words plus up to MAX_PAD padding words at end of line.
// A new pair is taken in the cycle the previous pair's last word moves to the output.
// Reset (arst_n low): phase, partial word, word count and stride go to zero, no words held.
module v210_ycbcr422_packer (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [v210_pkg::STRIDE_W-1:0] cfg_wdata,
	v210_pair_if.sink                pairs,
	v210_word_if.source              words
);
	import v210_pkg::*;

	stride_t  stride_q;
	phase_t   phase_q;
	partial_t partial_q;
	stride_t  wil_q;

	// item stage
	logic   valid_s1;
	word_t  w_s1 [NDATA];
	ndata_t nwd_s1;
	logic [NDATA_W-1:0] idx_s1;
	pad_t   pad_s1;
	logic   eol_s1;

	// output stage
	logic  valid_s2;
	word_t word_s2;
	logic  line_end_s2;
	logic  last_s2;

	sample_t  cb_c, y0_c, cr_c, y1_c;
	word_t    nw [NDATA];
	ndata_t   nwd;
	phase_t   phase_n;
	partial_t partial_n;
	logic [STRIDE_W:0] wil_sum;
	stride_t  wil_after;
	stride_t  pad_diff;
	pad_t     pad_n;
	logic     take;
	logic     data_phase;
	logic     cur_last;
	logic     emit_go;

	assign cb_c = clip_sample(pairs.cb);
	assign y0_c = clip_sample(pairs.y_first);
	assign cr_c = clip_sample(pairs.cr);
	assign y1_c = clip_sample(pairs.y_second);

	always_comb begin
		nw[0]     = '0;
		nw[1]     = '0;
		nw[2]     = '0;
		nwd       = ndata_t'(1);
		phase_n   = PH_START;
		partial_n = '0;
		unique case (phase_q)
			PH_ONE: begin
				nw[0]     = {2'b00, y0_c, cb_c, partial_q[SAMPLE_W-1:0]};
				partial_n = {y1_c, cr_c};
				phase_n   = PH_TWO;
			end
			PH_TWO: begin
				nw[0]     = {2'b00, cb_c, partial_q};
				nw[1]     = pack3(y0_c, cr_c, y1_c);
				nwd       = ndata_t'(2);
				phase_n   = PH_START;
			end
			PH_START, PH_UNUSED: begin
				nw[0]     = pack3(cb_c, y0_c, cr_c);
				partial_n = PARTIAL_W'(y1_c);
				phase_n   = PH_ONE;
			end
			default: begin
			end
		endcase
		// flush of a partial word at end of line
		if (pairs.end_of_line && phase_n != PH_START) begin
			nw[nwd[1:0]] = {{(WORD_W - PARTIAL_W){1'b0}}, partial_n};
			nwd          = nwd + ndata_t'(1);
		end
	end

	// saturating word count after this pair's data words
	assign wil_sum   = {1'b0, wil_q} + (STRIDE_W + 1)'(nwd);
	assign wil_after = wil_sum[STRIDE_W] ? WIL_MAX : wil_sum[STRIDE_W-1:0];
	assign pad_diff  = stride_q - wil_after;

	always_comb begin
		if (!pairs.end_of_line || stride_q <= wil_after) begin
			pad_n = '0;
		end else if (pad_diff > STRIDE_W'(MAX_PAD)) begin
			pad_n = PAD_W'(MAX_PAD);
		end else begin
			pad_n = pad_diff[PAD_W-1:0];
		end
	end

	// word sequencing out of the item stage
	assign data_phase = (ndata_t'(idx_s1) < nwd_s1);
	assign cur_last   = data_phase ? (ndata_t'(idx_s1) == nwd_s1 - ndata_t'(1) && pad_s1 == '0)
	                               : (pad_s1 == pad_t'(1));
	assign emit_go    = valid_s1 && (!valid_s2 || words.ready);
	assign take       = pairs.valid && pairs.ready;

	assign pairs.ready = !valid_s1 || (emit_go && cur_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stride_q <= '0;
		end else if (cfg_we) begin
			stride_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_START;
			partial_q <= '0;
			wil_q     <= '0;
		end else if (take) begin
			if (pairs.end_of_line) begin
				phase_q   <= PH_START;
				partial_q <= '0;
				wil_q     <= '0;
			end else begin
				phase_q   <= phase_n;
				partial_q <= partial_n;
				wil_q     <= wil_after;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_s1   <= '0;
			pad_s1   <= '0;
		end else if (take) begin
			valid_s1 <= 1'b1;
			idx_s1   <= '0;
			pad_s1   <= pad_n;
		end else if (emit_go) begin
			if (cur_last) begin
				valid_s1 <= 1'b0;
			end else if (data_phase) begin
				idx_s1 <= idx_s1 + (NDATA_W)'(1);
			end else begin
				pad_s1 <= pad_s1 - pad_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_s1[0] <= nw[0];
			w_s1[1] <= nw[1];
			w_s1[2] <= nw[2];
			nwd_s1  <= nwd;
			eol_s1  <= pairs.end_of_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (emit_go) begin
			valid_s2 <= 1'b1;
		end else if (words.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			word_s2     <= data_phase ? w_s1[idx_s1[1:0]] : '0;
			line_end_s2 <= eol_s1 && cur_last;
			last_s2     <= cur_last;
		end
	end

	assign words.valid       = valid_s2;
	assign words.word        = word_s2;
	assign words.line_end    = line_end_s2;
	assign words.last_of_run = last_s2;

endmodule
